@@ src/jsu_pkg.sv @@
package jsu_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [12:0] MAX_LENGTH_RESET = 13'd256;
    localparam logic [12:0] COUNT_MAX        = 13'h1FFF;

    localparam logic [3:0] ST_BUSY      = 4'd0;
    localparam logic [3:0] ST_DONE      = 4'd1;
    localparam logic [3:0] ST_NO_QUOTE  = 4'd2;
    localparam logic [3:0] ST_CONTROL   = 4'd3;
    localparam logic [3:0] ST_BAD_ESC   = 4'd4;
    localparam logic [3:0] ST_BAD_HEX   = 4'd5;
    localparam logic [3:0] ST_BAD_SURR  = 4'd6;
    localparam logic [3:0] ST_LOW_CP    = 4'd7;
    localparam logic [3:0] ST_TOO_LONG  = 4'd8;
    localparam logic [3:0] ST_TRUNCATED = 4'd9;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_N = 8'h6E;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_U = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [15:0] HI_SURR_MIN = 16'hD800;
    localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
    localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
    localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
    localparam logic [10:0] PLANE_BASE  = 11'h040;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BODY,
        PH_ESC,
        PH_HEX_HI,
        PH_EXP_BS,
        PH_EXP_U,
        PH_HEX_LO
    } phase_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            has_bytes;
        logic [3:0]      status;
    } run_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
    } utf8_t;

    function automatic logic [4:0] hex_digit_of(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic utf8_t encode_utf8(input logic [20:0] cp);
        utf8_t r;
        r.bytes = '0;
        if (cp <= 21'h7F)
        begin
            r.bytes[0] = cp[7:0];
            r.count = 3'd1;
        end
        else if (cp <= 21'h7FF)
        begin
            r.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
            r.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
            r.count = 3'd2;
        end
        else if (cp <= 21'hFFFF)
        begin
            r.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
            r.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
            r.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
            r.count = 3'd3;
        end
        else
        begin
            r.bytes[0] = 8'hF0 | {5'b00000, cp[20:18]};
            r.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
            r.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
            r.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
            r.count = 3'd4;
        end
        return r;
    endfunction

endpackage

@@ src/json_string_unescape_utf8_top.sv @@
// a byte's run of results is written into the queue on its input transfer, and the
// output register then loads its first result and offers it for transfer
// throughput: one input byte per cycle while the queue is not full; one result per cycle
// at the output while out_ready is high; a byte that decodes to n bytes gives n results
// a queue of QUEUE_DEPTH runs lets the decoder run ahead of the output port
// reset: asynchronous, clears parser, queue and output stage; max_length to 256
module json_string_unescape_utf8_top
#(
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_byte,
    input  logic        stream_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic [3:0]  status,
    output logic        last_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] max_length
);

    logic [12:0]   max_length_reg;
    logic          accept;
    logic          push;
    jsu_pkg::run_t run;
    logic          q_full;
    logic          q_not_empty;
    jsu_pkg::run_t q_head;
    logic          pop;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= jsu_pkg::MAX_LENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_length_reg <= max_length;
        end
    end

    jsu_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .char_byte  (char_byte),
        .stream_end (stream_end),
        .max_length (max_length_reg),
        .push       (push),
        .run        (run)
    );

    jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (run),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    jsu_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .status      (status),
        .last_of_run (last_of_run)
    );

`ifndef SYNTH
    a_byte_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid |-> status == jsu_pkg::ST_BUSY)
        else $error("decoded byte carries a nonzero status");

    a_nobyte_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> last_of_run)
        else $error("result without a byte is not the last of its run");

    a_stall_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled while the output stage is empty");

    a_fill_shows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> ##1 out_valid)
        else $error("accepted byte produced no result");
`endif

endmodule

@@ src/jsu_front.sv @@
module jsu_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         char_byte,
    input  logic               stream_end,
    input  logic [12:0]        max_length,
    output logic               push,
    output jsu_pkg::run_t      run
);

    jsu_pkg::phase_t phase_reg, phase_next;
    logic [15:0] acc_reg, acc_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;
    logic [10:0] plane_reg, plane_next;
    logic [12:0] count_reg, count_next;

    logic [4:0]     hex;
    logic [15:0]    acc_new;
    logic [20:0]    cp_sel;
    jsu_pkg::utf8_t enc;
    logic [3:0]     st_final;
    logic [2:0]     emit_n;
    logic [13:0]    count_sum;

    assign hex     = jsu_pkg::hex_digit_of(char_byte);
    assign acc_new = {acc_reg[11:0], hex[3:0]};
    assign cp_sel  = (phase_reg == jsu_pkg::PH_HEX_LO) ? {plane_reg, acc_new[9:0]}
                                                       : {5'd0, acc_new};
    assign enc     = jsu_pkg::encode_utf8(cp_sel);

    // classify the byte and build its run of results
    always_comb
    begin
        logic [3:0]      st;
        logic [3:0][7:0] b;
        logic [2:0]      n;
        st = jsu_pkg::ST_BUSY;
        b  = '0;
        n  = 3'd0;
        unique case (phase_reg)
            jsu_pkg::PH_IDLE:
            begin
                if (char_byte != jsu_pkg::CH_QUOTE)
                begin
                    st = jsu_pkg::ST_NO_QUOTE;
                end
            end
            jsu_pkg::PH_BODY:
            begin
                if (char_byte == jsu_pkg::CH_QUOTE)
                begin
                    st = (count_reg > max_length) ? jsu_pkg::ST_TOO_LONG : jsu_pkg::ST_DONE;
                end
                else if (char_byte < jsu_pkg::CH_SPACE)
                begin
                    st = jsu_pkg::ST_CONTROL;
                end
                else if (char_byte != jsu_pkg::CH_BSLASH)
                begin
                    b[0] = char_byte;
                    n = 3'd1;
                end
            end
            jsu_pkg::PH_ESC:
            begin
                n = 3'd1;
                case (char_byte)
                    jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
                        b[0] = char_byte;
                    jsu_pkg::CH_B: b[0] = 8'h08;
                    jsu_pkg::CH_F: b[0] = 8'h0C;
                    jsu_pkg::CH_N: b[0] = 8'h0A;
                    jsu_pkg::CH_R: b[0] = 8'h0D;
                    jsu_pkg::CH_T: b[0] = 8'h09;
                    jsu_pkg::CH_U: n = 3'd0;
                    default:
                    begin
                        n = 3'd0;
                        st = jsu_pkg::ST_BAD_ESC;
                    end
                endcase
            end
            jsu_pkg::PH_HEX_HI, jsu_pkg::PH_HEX_LO:
            begin
                if (!hex[4])
                begin
                    st = jsu_pkg::ST_BAD_HEX;
                end
                else if (hex_cnt_reg == 2'd3)
                begin
                    if (phase_reg == jsu_pkg::PH_HEX_HI)
                    begin
                        if (acc_new >= jsu_pkg::HI_SURR_MIN && acc_new <= jsu_pkg::HI_SURR_MAX)
                        begin
                            n = 3'd0;
                        end
                        else if (acc_new >= jsu_pkg::LO_SURR_MIN &&
                                 acc_new <= jsu_pkg::LO_SURR_MAX)
                        begin
                            st = jsu_pkg::ST_BAD_SURR;
                        end
                        else if (acc_new < 16'h0020)
                        begin
                            st = jsu_pkg::ST_LOW_CP;
                        end
                        else
                        begin
                            b = enc.bytes;
                            n = enc.count;
                        end
                    end
                    else if (acc_new < jsu_pkg::LO_SURR_MIN || acc_new > jsu_pkg::LO_SURR_MAX)
                    begin
                        st = jsu_pkg::ST_BAD_SURR;
                    end
                    else
                    begin
                        b = enc.bytes;
                        n = enc.count;
                    end
                end
            end
            jsu_pkg::PH_EXP_BS:
            begin
                if (char_byte != jsu_pkg::CH_BSLASH)
                begin
                    st = jsu_pkg::ST_BAD_SURR;
                end
            end
            jsu_pkg::PH_EXP_U:
            begin
                if (char_byte != jsu_pkg::CH_U)
                begin
                    st = jsu_pkg::ST_BAD_SURR;
                end
            end
            default:
            begin
                st = jsu_pkg::ST_NO_QUOTE;
            end
        endcase
        if (st == jsu_pkg::ST_BUSY && stream_end)
        begin
            st = jsu_pkg::ST_TRUNCATED;
        end
        if (st != jsu_pkg::ST_BUSY)
        begin
            n = 3'd0;
        end
        st_final       = st;
        emit_n         = n;
        run.bytes      = (n == 3'd0) ? '0 : b;
        run.has_bytes  = (n != 3'd0);
        run.last_idx   = (n == 3'd0) ? 2'd0 : 2'(n - 3'd1);
        run.status     = st;
    end

    assign push      = accept;
    assign count_sum = {1'b0, count_reg} + {11'd0, emit_n};

    always_comb
    begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        hex_cnt_next = hex_cnt_reg;
        plane_next   = plane_reg;
        count_next   = count_reg;
        if (accept)
        begin
            unique case (phase_reg)
                jsu_pkg::PH_IDLE:
                begin
                    if (char_byte == jsu_pkg::CH_QUOTE)
                    begin
                        phase_next   = jsu_pkg::PH_BODY;
                        count_next   = '0;
                        acc_next     = '0;
                        hex_cnt_next = '0;
                        plane_next   = '0;
                    end
                end
                jsu_pkg::PH_BODY:
                begin
                    if (char_byte == jsu_pkg::CH_BSLASH)
                    begin
                        phase_next = jsu_pkg::PH_ESC;
                    end
                end
                jsu_pkg::PH_ESC:
                begin
                    phase_next = jsu_pkg::PH_BODY;
                    if (char_byte == jsu_pkg::CH_U)
                    begin
                        phase_next   = jsu_pkg::PH_HEX_HI;
                        acc_next     = '0;
                        hex_cnt_next = '0;
                    end
                end
                jsu_pkg::PH_HEX_HI, jsu_pkg::PH_HEX_LO:
                begin
                    if (hex[4])
                    begin
                        acc_next = acc_new;
                        if (hex_cnt_reg != 2'd3)
                        begin
                            hex_cnt_next = hex_cnt_reg + 2'd1;
                        end
                        else
                        begin
                            hex_cnt_next = '0;
                            phase_next   = jsu_pkg::PH_BODY;
                            if (phase_reg == jsu_pkg::PH_HEX_HI &&
                                acc_new >= jsu_pkg::HI_SURR_MIN &&
                                acc_new <= jsu_pkg::HI_SURR_MAX)
                            begin
                                plane_next = {1'b0, acc_new[9:0]} + jsu_pkg::PLANE_BASE;
                                phase_next = jsu_pkg::PH_EXP_BS;
                            end
                        end
                    end
                end
                jsu_pkg::PH_EXP_BS:
                begin
                    if (char_byte == jsu_pkg::CH_BSLASH)
                    begin
                        phase_next = jsu_pkg::PH_EXP_U;
                    end
                end
                jsu_pkg::PH_EXP_U:
                begin
                    if (char_byte == jsu_pkg::CH_U)
                    begin
                        phase_next   = jsu_pkg::PH_HEX_LO;
                        acc_next     = '0;
                        hex_cnt_next = '0;
                    end
                end
                default:
                begin
                    phase_next = jsu_pkg::PH_IDLE;
                end
            endcase
            if (st_final != jsu_pkg::ST_BUSY)
            begin
                phase_next = jsu_pkg::PH_IDLE;
            end
            else if (emit_n != 3'd0)
            begin
                // saturating byte count
                count_next = count_sum[13] ? jsu_pkg::COUNT_MAX : count_sum[12:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= jsu_pkg::PH_IDLE;
            acc_reg     <= '0;
            hex_cnt_reg <= '0;
            plane_reg   <= '0;
            count_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            acc_reg     <= acc_next;
            hex_cnt_reg <= hex_cnt_next;
            plane_reg   <= plane_next;
            count_reg   <= count_next;
        end
    end

endmodule

@@ src/jsu_queue.sv @@
module jsu_queue
#(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  jsu_pkg::run_t push_data,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output jsu_pkg::run_t head
);

    // depth must be a power of two (unchecked) so the pointers wrap on their own
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jsu_pkg::run_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ src/jsu_back.sv @@
module jsu_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_not_empty,
    input  jsu_pkg::run_t q_head,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          byte_valid,
    output logic [3:0]    status,
    output logic          last_of_run
);

    jsu_pkg::run_t rec_reg, rec_next;
    logic          busy_reg, busy_next;
    logic [1:0]    idx_reg, idx_next;
    logic          is_last;
    logic          taken;

    assign is_last     = (idx_reg == rec_reg.last_idx);
    assign taken       = busy_reg && out_ready;
    assign pop         = q_not_empty && (!busy_reg || (taken && is_last));

    assign out_valid   = busy_reg;
    assign byte_valid  = rec_reg.has_bytes;
    assign out_byte    = rec_reg.has_bytes ? rec_reg.bytes[idx_reg] : 8'd0;
    assign status      = rec_reg.has_bytes ? jsu_pkg::ST_BUSY : rec_reg.status;
    assign last_of_run = is_last;

    always_comb
    begin
        rec_next  = rec_reg;
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (pop)
        begin
            rec_next  = q_head;
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (taken)
        begin
            if (is_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

endmodule

@@ sim/json_string_unescape_utf8_top_tb.sv @@
`timescale 1ns / 1ps

module json_string_unescape_utf8_top_tb;

    import jsu_pkg::*;

    typedef struct packed {
        logic [7:0] ob;
        logic       has_byte;
        logic [3:0] st;
        logic       run_end;
    } result_t;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      n;
    } enc_t;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic [7:0]  char_byte  = 8'h00;
    logic        stream_end = 1'b0;
    logic        out_ready  = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic [12:0] max_length = MAX_LENGTH_RESET;
    logic        in_ready;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic [3:0]  status;
    logic        last_of_run;
    logic        cfg_ready;

    // decoder state as the block should hold it
    phase_t      ph;
    logic [15:0] acc;
    logic [15:0] hi_unit;
    logic [1:0]  ndig;
    logic [12:0] dec_count;
    logic [12:0] max_len_model;

    result_t decoded_results_q[$];

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    logic out_hold      = 1'b0;
    int bytes_sent      = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int cfg_writes      = 0;
    int status_hits[16];

    json_string_unescape_utf8_top dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_byte   (char_byte),
        .stream_end  (stream_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .status      (status),
        .last_of_run (last_of_run),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .max_length  (max_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10)
            return "0" + 8'(n);
        return (upper ? "A" : "a") + 8'(n - 4'd10);
    endfunction

    function automatic enc_t utf8_of(input logic [20:0] cp);
        enc_t r;
        r = '0;
        if (cp < 21'h80)
        begin
            r.n = 3'd1;
            r.b[0] = cp[7:0];
        end
        else if (cp < 21'h800)
        begin
            r.n = 3'd2;
            r.b[0] = {3'b110, cp[10:6]};
            r.b[1] = {2'b10, cp[5:0]};
        end
        else if (cp < 21'h10000)
        begin
            r.n = 3'd3;
            r.b[0] = {4'b1110, cp[15:12]};
            r.b[1] = {2'b10, cp[11:6]};
            r.b[2] = {2'b10, cp[5:0]};
        end
        else
        begin
            r.n = 3'd4;
            r.b[0] = {5'b11110, cp[20:18]};
            r.b[1] = {2'b10, cp[17:12]};
            r.b[2] = {2'b10, cp[11:6]};
            r.b[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

    function automatic bit is_escape_letter(input logic [7:0] c);
        case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] rand_plain();
        logic [7:0] c;
        do
            c = 8'($urandom_range(32, 255));
        while (c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    task automatic reset_model();
        ph = PH_IDLE;
        acc = '0;
        hi_unit = '0;
        ndig = '0;
        dec_count = '0;
        max_len_model = MAX_LENGTH_RESET;
    endtask

    // works out the results that one accepted byte causes
    task automatic decode_char(input logic [7:0] c, input logic is_last);
        enc_t    out;
        logic [3:0] st;
        int      d;
        int      k;
        result_t r;
        out = '0;
        st = ST_BUSY;
        case (ph)
            PH_BODY:
            begin
                if (c == CH_QUOTE)
                    st = (dec_count > max_len_model) ? ST_TOO_LONG : ST_DONE;
                else if (c < CH_SPACE)
                    st = ST_CONTROL;
                else if (c == CH_BSLASH)
                    ph = PH_ESC;
                else
                begin
                    out.n = 3'd1;
                    out.b[0] = c;
                end
            end
            PH_ESC:
            begin
                ph = PH_BODY;
                out.n = 3'd1;
                case (c)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: out.b[0] = c;
                    CH_B: out.b[0] = 8'h08;
                    CH_F: out.b[0] = 8'h0C;
                    CH_N: out.b[0] = 8'h0A;
                    CH_R: out.b[0] = 8'h0D;
                    CH_T: out.b[0] = 8'h09;
                    CH_U:
                    begin
                        out.n = 3'd0;
                        ph = PH_HEX_HI;
                        acc = '0;
                        ndig = '0;
                    end
                    default:
                    begin
                        out.n = 3'd0;
                        st = ST_BAD_ESC;
                    end
                endcase
            end
            PH_HEX_HI, PH_HEX_LO:
            begin
                d = nibble_of(c);
                if (d < 0)
                    st = ST_BAD_HEX;
                else
                begin
                    acc = {acc[11:0], 4'(d)};
                    if (ndig != 2'd3)
                        ndig = ndig + 2'd1;
                    else
                    begin
                        ndig = '0;
                        if (ph == PH_HEX_HI)
                        begin
                            if (acc >= HI_SURR_MIN && acc <= HI_SURR_MAX)
                            begin
                                hi_unit = acc;
                                ph = PH_EXP_BS;
                            end
                            else if (acc >= LO_SURR_MIN && acc <= LO_SURR_MAX)
                                st = ST_BAD_SURR;
                            else if (acc < {8'h00, CH_SPACE})
                                st = ST_LOW_CP;
                            else
                            begin
                                out = utf8_of({5'd0, acc});
                                ph = PH_BODY;
                            end
                        end
                        else if (acc < LO_SURR_MIN || acc > LO_SURR_MAX)
                            st = ST_BAD_SURR;
                        else
                        begin
                            out = utf8_of(21'h10000 + {1'b0, hi_unit[9:0], acc[9:0]});
                            ph = PH_BODY;
                        end
                    end
                end
            end
            PH_EXP_BS:
            begin
                if (c == CH_BSLASH)
                    ph = PH_EXP_U;
                else
                    st = ST_BAD_SURR;
            end
            PH_EXP_U:
            begin
                if (c == CH_U)
                begin
                    ph = PH_HEX_LO;
                    acc = '0;
                    ndig = '0;
                end
                else
                    st = ST_BAD_SURR;
            end
            default:
            begin
                ph = PH_IDLE;
                if (c == CH_QUOTE)
                begin
                    ph = PH_BODY;
                    dec_count = '0;
                    acc = '0;
                    hi_unit = '0;
                    ndig = '0;
                end
                else
                    st = ST_NO_QUOTE;
            end
        endcase

        if (st == ST_BUSY && is_last)
            st = ST_TRUNCATED;
        if (st != ST_BUSY || out.n == 3'd0)
        begin
            if (st != ST_BUSY)
                ph = PH_IDLE;
            r = '{ob: 8'h00, has_byte: 1'b0, st: st, run_end: 1'b1};
            decoded_results_q.insert(decoded_results_q.size(), r);
        end
        else
        begin
            for (k = 0; k < out.n; k++)
            begin
                r = '{ob: out.b[k], has_byte: 1'b1, st: ST_BUSY, run_end: (k == out.n - 1)};
                decoded_results_q.insert(decoded_results_q.size(), r);
                if (dec_count != COUNT_MAX)
                    dec_count = dec_count + 13'd1;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatches++;
        if (mismatches <= 30)
            $display("mismatch on result %0d: %s got %h expected %h",
                     results_checked, what, got, want);
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            status_hits[status]++;
            if (decoded_results_q.size() == 0)
                report_mismatch("transfer with nothing pending, status",
                                16'(status), 16'(ST_BUSY));
            else
            begin
                want = decoded_results_q.pop_front();
                if (out_byte !== want.ob)
                    report_mismatch("out_byte", 16'(out_byte), 16'(want.ob));
                if (byte_valid !== want.has_byte)
                    report_mismatch("byte_valid", 16'(byte_valid), 16'(want.has_byte));
                if (status !== want.st)
                    report_mismatch("status", 16'(status), 16'(want.st));
                if (last_of_run !== want.run_end)
                    report_mismatch("last_of_run", 16'(last_of_run), 16'(want.run_end));
            end
        end
    end

    always @(posedge clk)
    begin
        out_ready <= !out_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_byte(input logic [7:0] c, input logic is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        char_byte <= c;
        stream_end <= is_last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        decode_char(c, is_last);
        bytes_sent++;
    endtask

    task automatic send_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    task automatic send_unit(input logic [15:0] u);
        int i;
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_U, 1'b0);
        for (i = 3; i >= 0; i--)
            send_byte(hex_char(u[4*i +: 4], 1'($urandom_range(1))), 1'b0);
    endtask

    task automatic send_long_string(input int n);
        int i;
        send_byte(CH_QUOTE, 1'b0);
        for (i = 0; i < n; i++)
            send_byte(rand_plain(), 1'b0);
        send_byte(CH_QUOTE, 1'b0);
    endtask

    task automatic send_noise();
        int i;
        int n;
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++)
            send_byte(8'($urandom_range(0, 255)), $urandom_range(9) == 0);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (decoded_results_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_max_length(input logic [12:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        max_length <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        max_len_model = v;
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic pick_random_limit();
        case ($urandom_range(4))
            0: write_max_length(13'd0);
            1: write_max_length(13'h1FFF);
            2: write_max_length(13'd4096);
            3: write_max_length(13'($urandom_range(0, 24)));
            default: write_max_length(13'($urandom_range(0, 8191)));
        endcase
    endtask

    function automatic logic [15:0] rand_bmp_unit();
        case ($urandom_range(3))
            0: return 16'($urandom_range(16'h20, 16'h7F));
            1: return 16'($urandom_range(16'h80, 16'h7FF));
            2: return 16'($urandom_range(16'h800, 16'hD7FF));
            default: return 16'($urandom_range(16'hE000, 16'hFFFF));
        endcase
    endfunction

    // mostly well-formed strings with random content, some broken or cut short
    task automatic random_string();
        int i;
        int n;
        int pick;
        logic [7:0] c;
        logic [15:0] u;
        if ($urandom_range(99) < 20)
            send_noise();
        send_byte(CH_QUOTE, 1'b0);
        n = $urandom_range(0, 4);
        for (i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                send_byte(rand_plain(), 1'b0);
            else if (pick < 60)
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (!is_escape_letter(c) || c == CH_U);
                send_byte(CH_BSLASH, 1'b0);
                send_byte(c, 1'b0);
            end
            else if (pick < 80)
                send_unit(rand_bmp_unit());
            else
            begin
                send_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
                send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end
        end
        pick = $urandom_range(99);
        if (pick < 65)
            send_byte(CH_QUOTE, $urandom_range(9) == 0);
        else if (pick < 75)
            send_byte($urandom_range(1) ? rand_plain() : CH_BSLASH, 1'b1);
        else
        begin
            case ($urandom_range(7))
                0: send_byte(8'($urandom_range(0, 31)), 1'($urandom_range(1)));
                1:
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (is_escape_letter(c));
                    send_byte(CH_BSLASH, 1'b0);
                    send_byte(c, 1'b0);
                end
                2:
                begin
                    if ($urandom_range(1))
                        send_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
                    send_byte(CH_BSLASH, 1'b0);
                    send_byte(CH_U, 1'b0);
                    n = $urandom_range(0, 3);
                    for (i = 0; i < n; i++)
                        send_byte(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))),
                                  1'b0);
                    do
                        c = 8'($urandom_range(0, 255));
                    while (nibble_of(c) >= 0);
                    send_byte(c, 1'b0);
                end
                3: send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
                4:
                begin
                    send_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c == CH_BSLASH);
                    send_byte(c, 1'b0);
                end
                5:
                begin
                    send_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c == CH_U);
                    send_byte(CH_BSLASH, 1'b0);
                    send_byte(c, 1'b0);
                end
                6:
                begin
                    send_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
                    do
                        u = 16'($urandom_range(0, 16'hFFFF));
                    while (u >= LO_SURR_MIN && u <= LO_SURR_MAX);
                    send_unit(u);
                end
                default: send_unit(16'($urandom_range(0, 16'h1F)));
            endcase
            if ($urandom_range(99) < 40)
                send_noise();
        end
    endtask

    task automatic test_reset_limit();
        send_long_string(4);
    endtask

    task automatic test_simple_escapes();
        send_byte("A", 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_str(" \\\"\\\\\\/\\b\\f\\n\\r\\t\"");
    endtask

    task automatic test_unicode();
        send_str("\"\\u00e9\\u20AC\\uD83D\\ude00\"");
    endtask

    task automatic test_errors();
        send_str("\"a");
        send_byte(8'h1F, 1'b0);
        send_str("\"\\x");
        send_str("\"\\u0G");
        send_str("\"\\uDC00");
        send_str("\"\\u001F");
    endtask

    task automatic test_stream_end();
        send_byte(CH_QUOTE, 1'b1);
        send_byte("Z", 1'b1);
        send_str("\"a");
        send_byte("b", 1'b1);
        send_str("\"\\u00e");
        send_byte("9", 1'b1);
    endtask

    task automatic test_length_limit();
        write_max_length(13'd0);
        send_str("\"\"\"a\"");
        write_max_length(13'd2);
        send_str("\"ab\"\"\\u20AC\"");
    endtask

    task automatic test_random(input int n);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n)
        begin
            if ($urandom_range(99) < 15)
                pick_random_limit();
            random_string();
        end
    endtask

    // receiver stalls long enough for the block to fill and push back
    task automatic test_backpressure();
        int keep_idle;
        int start;
        keep_idle = send_idle_pct;
        send_idle_pct = 0;
        wait_drained();
        fork
            begin
                out_hold <= 1'b1;
                repeat (150) @(posedge clk);
                out_hold <= 1'b0;
            end
        join_none
        start = bytes_sent;
        while (bytes_sent - start < 16)
            random_string();
        wait_drained();
        send_idle_pct = keep_idle;
    endtask

    initial
    begin
        int distinct;
        int i;
        reset_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 25;
        recv_idle_pct = 53;
        test_reset_limit();
        test_simple_escapes();
        test_unicode();
        test_errors();
        test_stream_end();
        test_length_limit();
        test_random(10);
        wait_drained();

        send_idle_pct = 53;
        recv_idle_pct = 25;
        pick_random_limit();
        test_random(10);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_max_length(13'($urandom_range(0, 24)));
        test_random(10);
        test_backpressure();

        wait_drained();
        repeat (16) @(posedge clk);

        distinct = 0;
        for (i = 0; i < 16; i++)
            if (status_hits[i] != 0)
                distinct++;
        $display("sent %0d bytes, checked %0d results, %0d max_length writes",
                 bytes_sent, results_checked, cfg_writes);
        $display("saw %0d distinct status codes over escapes, surrogates, errors and stalls",
                 distinct);
        if (mismatches == 0 && decoded_results_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
